/* sv/mcbd_pkg.sv */
// shared types, codes and defaults for the multi-channel button debouncer
package mcbd_pkg;

    localparam int DEF_CHANNELS = 8;

    localparam int CHAN_W    = 3;
    localparam int PHASE_W   = 3;
    localparam int LOCK_W    = 32;
    localparam int DEBOUNCE_W = 16;
    localparam int TYPES_W   = 16;
    localparam int ENABLE_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [PHASE_W-1:0] {
        PH_INIT,
        PH_IDLE,
        PH_PRESS_LOCK,
        PH_ACTIVE,
        PH_RELEASE_LOCK
    } phase_t;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BUTTON = 2'd0;
    localparam kind_t KIND_TOGGLE = 2'd1;
    localparam kind_t KIND_SWITCH = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_DEBOUNCE_TIME  = 2'd0;
    localparam cfg_idx_t REG_CHANNEL_TYPES  = 2'd1;
    localparam cfg_idx_t REG_CHANNEL_ENABLE = 2'd2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd5;
    localparam logic [TYPES_W-1:0]    TYPES_RESET    = 16'd0;
    localparam logic [ENABLE_W-1:0]   ENABLE_RESET   = 8'hFF;

    typedef struct packed {
        phase_t              phase;
        logic                status;
        logic [LOCK_W-1:0]   lockout;
    } entry_t;

    typedef struct packed {
        logic   en;
        entry_t data;
    } ram_wr_t;

endpackage

/* sv/mcbd_state_ram.sv */
// per-channel state memory with valid bits and write-to-read forwarding
module mcbd_state_ram #(
    parameter int CHANNELS = mcbd_pkg::DEF_CHANNELS,
    parameter int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output mcbd_pkg::entry_t rd_entry,
    input  mcbd_pkg::ram_wr_t wr,
    input  logic [AW-1:0]    wr_addr
);
    import mcbd_pkg::*;

    entry_t              mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic                fwd;

    assign fwd = wr.en && (wr_addr == rd_addr);

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= fwd ? wr.data : mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= fwd || valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset state
    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

/* sv/multi_channel_button_debouncer.sv */
// top level of the multi-channel button debouncer
// Debounces up to eight active-low push inputs, each typed as a momentary
// button, a toggle button or a switch. Each transaction on the s_ channel
// is an update (pin level) or a status query for one channel, and yields
// exactly one m_ transaction with the channel's status and phase. Channel
// state lives in a small synchronous memory: an accepted transaction's
// entry is read into a register, the updated entry is written back as the
// result moves from s1 to the m_ register and the write is forwarded into
// a read of the same channel, so one transaction is taken every cycle
// while m_ready stays high. The shared 32-bit step counter advances on each
// update to an existing, enabled channel. State is ready at once after
// reset; the user must write configuration through cfg_we, cfg_index and
// cfg_wdata while no transaction is in flight; the block does not check.
module multi_channel_button_debouncer #(
    parameter int CHANNELS = mcbd_pkg::DEF_CHANNELS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [mcbd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcbd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_operation,
    input  logic [mcbd_pkg::CHAN_W-1:0]     s_channel,
    input  logic                            s_pin_level,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mcbd_pkg::CHAN_W-1:0]     m_out_channel,
    output logic                            m_pressed_status,
    output logic [mcbd_pkg::PHASE_W-1:0]    m_phase,
    output logic                            m_ignored
);
    import mcbd_pkg::*;

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IW = (AW > CHAN_W) ? AW : CHAN_W;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [TYPES_W-1:0]    types_reg;
    logic [ENABLE_W-1:0]   enable_reg;
    logic [LOCK_W-1:0]     step_counter_reg;

    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic [CHAN_W-1:0]     s1_chan_reg;
    logic                  s1_level_reg;
    logic                  s1_exists_reg;
    logic [AW-1:0]         s1_addr_reg;

    logic                  m_valid_reg;
    logic [CHAN_W-1:0]     m_chan_reg;
    logic                  m_status_reg;
    logic [PHASE_W-1:0]    m_phase_reg;
    logic                  m_ignored_reg;

    logic                  accept;
    logic                  s1_advance;
    logic                  in_exists;
    logic [IW-1:0]         in_chan_ext;
    logic [AW-1:0]         in_addr;

    entry_t                cur;
    entry_t                entry_next;
    ram_wr_t               wr;
    kind_t                 kind;
    logic                  is_btn;
    logic                  is_update;
    logic [LOCK_W-1:0]     lock_end;
    logic                  lock_over;
    logic                  res_status;
    logic [PHASE_W-1:0]    res_phase;

    assign s1_advance = !m_valid_reg || m_ready;
    assign s_ready    = !s1_valid_reg || s1_advance;
    assign accept     = s_valid && s_ready;

    assign in_chan_ext = IW'(s_channel);
    assign in_exists   = {29'b0, s_channel} < 32'(CHANNELS);
    assign in_addr     = in_exists ? in_chan_ext[AW-1:0] : '0;

    mcbd_state_ram #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_ram (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (accept),
        .rd_addr  (in_addr),
        .rd_entry (cur),
        .wr       (wr),
        .wr_addr  (s1_addr_reg)
    );

    // phase rules for the entry in flight
    always_comb begin
        kind      = types_reg[{s1_chan_reg, 1'b0} +: 2];
        is_btn    = (kind == KIND_BUTTON) || (kind == KIND_TOGGLE);
        is_update = !s1_op_reg && s1_exists_reg && enable_reg[s1_chan_reg];
        lock_end  = cur.lockout + LOCK_W'(debounce_reg);
        lock_over = lock_end < step_counter_reg;
        entry_next = cur;
        unique case (cur.phase)
            PH_INIT: begin
                entry_next.phase = PH_IDLE;
            end
            PH_IDLE: begin
                if (!s1_level_reg) begin
                    if (is_btn) begin
                        entry_next.lockout = step_counter_reg;
                        entry_next.phase   = PH_PRESS_LOCK;
                        entry_next.status  = (kind == KIND_BUTTON) ? 1'b1 : !cur.status;
                    end else if (kind == KIND_SWITCH) begin
                        entry_next.phase  = PH_ACTIVE;
                        entry_next.status = 1'b1;
                    end
                end
            end
            PH_PRESS_LOCK: begin
                if (lock_over) begin
                    entry_next.phase   = PH_ACTIVE;
                    entry_next.lockout = '0;
                end
            end
            PH_ACTIVE: begin
                if (s1_level_reg) begin
                    if (is_btn) begin
                        entry_next.lockout = step_counter_reg;
                        entry_next.phase   = PH_RELEASE_LOCK;
                        if (kind == KIND_BUTTON) begin
                            entry_next.status = 1'b0;
                        end
                    end else if (kind == KIND_SWITCH) begin
                        entry_next.status = 1'b0;
                        entry_next.phase  = PH_IDLE;
                    end
                end
            end
            PH_RELEASE_LOCK: begin
                if (lock_over) begin
                    entry_next.phase   = PH_IDLE;
                    entry_next.lockout = '0;
                end
            end
            default: begin
                entry_next = cur;
            end
        endcase

        wr.en   = s1_valid_reg && s1_advance && is_update;
        wr.data = entry_next;

        if (!s1_exists_reg) begin
            res_status = 1'b0;
            res_phase  = PH_INIT;
        end else if (is_update) begin
            res_status = entry_next.status;
            res_phase  = entry_next.phase;
        end else begin
            res_status = cur.status;
            res_phase  = cur.phase;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg     <= DEBOUNCE_RESET;
            types_reg        <= TYPES_RESET;
            enable_reg       <= ENABLE_RESET;
            step_counter_reg <= '0;
            s1_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_DEBOUNCE_TIME:  debounce_reg <= cfg_wdata[DEBOUNCE_W-1:0];
                    REG_CHANNEL_TYPES:  types_reg    <= cfg_wdata[TYPES_W-1:0];
                    REG_CHANNEL_ENABLE: enable_reg   <= cfg_wdata[ENABLE_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (wr.en) begin
                step_counter_reg <= step_counter_reg + 1'b1;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_advance) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_op_reg     <= s_operation;
            s1_chan_reg   <= s_channel;
            s1_level_reg  <= s_pin_level;
            s1_exists_reg <= in_exists;
            s1_addr_reg   <= in_addr;
        end
        if (s1_valid_reg && s1_advance) begin
            m_chan_reg    <= s1_chan_reg;
            m_status_reg  <= res_status;
            m_phase_reg   <= res_phase;
            m_ignored_reg <= !s1_op_reg && !is_update;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_channel    = m_chan_reg;
    assign m_pressed_status = m_status_reg;
    assign m_phase          = m_phase_reg;
    assign m_ignored        = m_ignored_reg;

endmodule
